// ===== rtl/csfp_pkg.sv =====
// Shared types, frame letter codes and parse phase codes for the setpoint frame parser.
// No dependencies.
package csfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 15;
  localparam int unsigned PhaseW = 3;

  // frame letters
  localparam logic [ByteW-1:0] ChHead1  = 8'h4C;  // 'L'
  localparam logic [ByteW-1:0] ChHead2  = 8'h4D;  // 'M'
  localparam logic [ByteW-1:0] ChTarget = 8'h4A;  // 'J'
  localparam logic [ByteW-1:0] ChReal   = 8'h4B;  // 'K'
  localparam logic [ByteW-1:0] ChEnd    = 8'h5A;  // 'Z'

  // parse phases
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhHead  = 3'd1;
  localparam logic [PhaseW-1:0] PhAddr  = 3'd2;
  localparam logic [PhaseW-1:0] PhData1 = 3'd3;
  localparam logic [PhaseW-1:0] PhData2 = 3'd4;
  localparam logic [PhaseW-1:0] PhDataE = 3'd5;
  localparam logic [PhaseW-1:0] PhCheck = 3'd6;

  typedef struct packed {
    logic              emit;
    logic [ValueW-1:0] target_value;
    logic [ValueW-1:0] real_value;
  } csfp_result_t;

  // high nibble * 10 + low nibble, at most 165
  function automatic logic [ByteW-1:0] bcd_like(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// ===== rtl/csfp_if.sv =====
// Handshake channels of the setpoint frame parser: received bytes in, setpoint pairs out.
// Depends on csfp_pkg.
interface csfp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [csfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface csfp_result_if;
  logic                       valid;
  logic                       ready;
  logic [csfp_pkg::ValueW-1:0] target_value;
  logic [csfp_pkg::ValueW-1:0] real_value;

  modport source (output valid, output target_value, output real_value, input ready);
  modport sink   (input valid, input target_value, input real_value, output ready);
endinterface

// ===== rtl/csfp_in_stage.sv =====
// Input register of the setpoint frame parser: holds one received byte until it is parsed.
// Depends on csfp_pkg.
module csfp_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [csfp_pkg::ByteW-1:0] byte_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [csfp_pkg::ByteW-1:0] byte_o
);
  import csfp_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  // free when empty or when the held byte is consumed this cycle
  assign ready_o = !valid_q || take_i;
  // a new beat refills the register; otherwise a taken byte empties it
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/csfp_core.sv =====
// Frame state machine, running checksum and pending setpoints of the frame parser.
// Depends on csfp_pkg.
module csfp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [csfp_pkg::ByteW-1:0] byte_i,
  output csfp_pkg::csfp_result_t     res_o
);
  import csfp_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic              dbg_q, dbg_d;
  logic [ValueW-1:0] tgt_q, tgt_d;
  logic [ValueW-1:0] rel_q, rel_d;
  logic              emit;
  logic [ByteW-1:0]  sum_add;
  logic [ByteW-1:0]  conv;
  logic [ValueW-1:0] hundreds;

  assign sum_add  = sum_q + byte_i;
  assign conv     = bcd_like(byte_i);
  assign hundreds = ValueW'({7'd0, conv} * 15'd100);

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    dbg_d   = dbg_q;
    tgt_d   = tgt_q;
    rel_d   = rel_q;
    emit    = 1'b0;
    if (fire_i) begin
      if (phase_q == PhCheck) begin
        // letters mean nothing here; wait for the sum
        if (byte_i == sum_q) begin
          emit    = 1'b1;
          phase_d = PhIdle;
        end
      end else begin
        case (byte_i)
          ChHead1: begin
            phase_d = PhHead;
            sum_d   = byte_i;
          end
          ChHead2: begin
            if (phase_q == PhHead) begin
              phase_d = PhAddr;
              sum_d   = sum_add;
            end else begin
              phase_d = PhIdle;
              sum_d   = '0;
            end
          end
          ChTarget, ChReal: begin
            if (phase_q == PhAddr) begin
              phase_d = PhData1;
              sum_d   = sum_add;
              dbg_d   = (byte_i == ChReal);
            end else begin
              phase_d = PhIdle;
              sum_d   = '0;
            end
          end
          ChEnd: begin
            if (phase_q == PhDataE) begin
              phase_d = PhCheck;
              sum_d   = sum_add;
            end else begin
              phase_d = PhIdle;
              sum_d   = '0;
            end
          end
          default: begin
            if (phase_q == PhData1) begin
              phase_d = PhData2;
              sum_d   = sum_add;
              if (dbg_q) rel_d = hundreds;
              else       tgt_d = hundreds;
            end else if (phase_q == PhData2) begin
              phase_d = PhDataE;
              sum_d   = sum_add;
              if (dbg_q) rel_d = rel_q + ValueW'(conv);
              else       tgt_d = tgt_q + ValueW'(conv);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      sum_q   <= '0;
      dbg_q   <= 1'b0;
      tgt_q   <= '0;
      rel_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      dbg_q   <= dbg_d;
      tgt_q   <= tgt_d;
      rel_q   <= rel_d;
    end
  end

  assign res_o.emit         = emit;
  assign res_o.target_value = tgt_q;
  assign res_o.real_value   = rel_q;

  a_emit_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> phase_q == PhCheck)
    else $error("result outside check phase");

  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> phase_q == PhIdle)
    else $error("parser not idle after result");

  a_head_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHead |-> sum_q == ChHead1)
    else $error("bad sum in head phase");

  a_addr_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhAddr |-> sum_q == ByteW'(ChHead1 + ChHead2))
    else $error("bad sum in addr phase");

endmodule

// ===== rtl/csfp_out_stage.sv =====
// Result register of the setpoint frame parser: holds one setpoint pair until taken.
// Depends on csfp_pkg.
module csfp_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csfp_pkg::csfp_result_t      res_i,
  output logic                        free_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [csfp_pkg::ValueW-1:0] target_value_o,
  output logic [csfp_pkg::ValueW-1:0] real_value_o
);
  import csfp_pkg::*;

  logic              valid_q;
  logic [ValueW-1:0] tgt_q;
  logic [ValueW-1:0] rel_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && res_i.emit) begin
      tgt_q <= res_i.target_value;
      rel_q <= res_i.real_value;
    end
  end

  assign valid_o        = valid_q;
  assign target_value_o = tgt_q;
  assign real_value_o   = rel_q;

endmodule

// ===== rtl/checksummed_setpoint_frame_parser.sv =====
// Setpoint frame parser: received UART bytes in, committed setpoint pairs out.
// Depends on csfp_pkg, csfp_if, csfp_in_stage, csfp_core and csfp_out_stage.
//
// Takes one byte a beat and parses the frame 'L' 'M' cmd d1 d2 'Z' sum, where cmd 'J'
// loads the target setpoint and 'K' the debug real value, each data byte being read as
// high nibble * 10 + low nibble and the pair as d1 * 100 + d2. When a byte after 'Z'
// equals the 8-bit sum of the six frame bytes, one result beat carries both pending
// values; on a mismatch the parser keeps waiting for a byte that matches. An 'L' outside
// the checksum wait restarts the frame; any other frame letter out of place drops the
// parser to idle. A byte passes through an input register and is parsed by single-level
// logic into the result register. The block takes one byte per clock as long as the result
// side keeps up; a held result stalls parsing only while the result register is occupied.
module checksummed_setpoint_frame_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  csfp_byte_if.sink            in_if,
  csfp_result_if.source        out_if
);
  import csfp_pkg::*;

  logic             stage_valid;
  logic [ByteW-1:0] stage_byte;
  logic             out_free;
  logic             fire;
  csfp_result_t     core_res;

  // a held byte is parsed once the result register can take whatever it yields
  assign fire = stage_valid && out_free;

  csfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_if.valid),
    .ready_o (in_if.ready),
    .byte_i  (in_if.rx_byte),
    .take_i  (fire),
    .valid_o (stage_valid),
    .byte_o  (stage_byte)
  );

  csfp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (stage_byte),
    .res_o  (core_res)
  );

  csfp_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (core_res),
    .free_o         (out_free),
    .valid_o        (out_if.valid),
    .ready_i        (out_if.ready),
    .target_value_o (out_if.target_value),
    .real_value_o   (out_if.real_value)
  );

endmodule

// ===== verif/checksummed_setpoint_frame_parser_test.sv =====
// Self-checking testbench for the setpoint frame parser: byte stream in, setpoint pairs out.
// Depends on csfp_pkg, csfp_if and the checksummed_setpoint_frame_parser RTL.
// A ledger class parses every accepted byte alongside the block and checks each pair.
`timescale 1ns / 1ps

module checksummed_setpoint_frame_parser_test;
  import csfp_pkg::*;

  localparam int ClkPeriod   = 4;
  localparam int ResetCycles = 10;
  localparam int StreamLen   = 1350;  // least number of bytes offered, directed ones included
  localparam int HoldCycles  = 400;   // one long result-side stall to back the block up
  localparam int HoldAfter   = 25;    // pairs seen before that stall starts
  localparam int DrainCycles = 8;     // margin after the last owed pair is seen
  // Longest quiet spell in a correct run is the long stall plus one long gap; allow plenty.
  localparam int QuietLimit  = 3000;

  typedef struct packed {
    logic [ValueW-1:0] target_value;
    logic [ValueW-1:0] real_value;
  } setpoint_pair_t;

  // Tracks the frame parse from accepted bytes and holds the pairs the block owes us.
  class setpoint_ledger;
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  running_total;
    logic              load_real;
    logic [ValueW-1:0] pend_target;
    logic [ValueW-1:0] pend_real;
    setpoint_pair_t    committed_pairs[$];
    int                pairs_checked;
    int                fails;

    function new();
      phase         = PhIdle;
      running_total = '0;
      load_real     = 1'b0;
      pend_target   = '0;
      pend_real     = '0;
      pairs_checked = 0;
      fails         = 0;
    endfunction

    function void abandon();
      phase         = PhIdle;
      running_total = '0;
    endfunction

    function int outstanding();
      return committed_pairs.size();
    endfunction

    // Advance the parse by one accepted byte; a matching checksum commits a pair.
    function void take_byte(logic [ByteW-1:0] b);
      int unsigned digits;
      if (phase == PhCheck) begin
        // letters mean nothing here, only the checksum counts
        if (b == running_total) begin
          committed_pairs.push_back('{pend_target, pend_real});
          phase = PhIdle;
        end
        return;
      end
      case (b)
        ChHead1: begin
          phase         = PhHead;
          running_total = b;
        end
        ChHead2: begin
          if (phase == PhHead) begin
            running_total += b;
            phase = PhAddr;
          end else begin
            abandon();
          end
        end
        ChTarget, ChReal: begin
          if (phase == PhAddr) begin
            running_total += b;
            load_real = (b == ChReal);
            phase     = PhData1;
          end else begin
            abandon();
          end
        end
        ChEnd: begin
          if (phase == PhDataE) begin
            running_total += b;
            phase = PhCheck;
          end else begin
            abandon();
          end
        end
        default: begin
          digits = int'(b[7:4]) * 10 + int'(b[3:0]);
          if (phase == PhData1) begin
            running_total += b;
            if (load_real) pend_real = ValueW'(digits * 100);
            else pend_target = ValueW'(digits * 100);
            phase = PhData2;
          end else if (phase == PhData2) begin
            running_total += b;
            if (load_real) pend_real += ValueW'(digits);
            else pend_target += ValueW'(digits);
            phase = PhDataE;
          end
          // anything else outside the data phases is dropped silently
        end
      endcase
    endfunction

    function void check_pair(logic [ValueW-1:0] tgt, logic [ValueW-1:0] rl);
      setpoint_pair_t owed;
      pairs_checked++;
      if (committed_pairs.size() == 0) begin
        $display("%0t: unexpected pair target=%0d real=%0d", $time, tgt, rl);
        fails++;
        return;
      end
      owed = committed_pairs.pop_front();
      if (owed.target_value !== tgt) begin
        $display("%0t: target_value expected %0d, got %0d", $time, owed.target_value, tgt);
        fails++;
      end
      if (owed.real_value !== rl) begin
        $display("%0t: real_value expected %0d, got %0d", $time, owed.real_value, rl);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  csfp_byte_if   byte_ch ();
  csfp_result_if result_ch ();

  checksummed_setpoint_frame_parser uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (byte_ch.sink),
    .out_if (result_ch.source)
  );

  setpoint_ledger   ledger = new();
  logic [ByteW-1:0] rx_stream[$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // 8-bit wrapping sum of the six frame bytes ahead of the checksum
  function automatic logic [ByteW-1:0] frame_sum(logic [ByteW-1:0] cmd, logic [ByteW-1:0] d1,
                                                 logic [ByteW-1:0] d2);
    return ChHead1 + ChHead2 + cmd + d1 + d2 + ChEnd;
  endfunction

  // Header, command, data and end letter; the checksum beat is left to the caller.
  function automatic void push_frame(logic [ByteW-1:0] cmd, logic [ByteW-1:0] d1,
                                     logic [ByteW-1:0] d2);
    rx_stream.push_back(ChHead1);
    rx_stream.push_back(ChHead2);
    rx_stream.push_back(cmd);
    rx_stream.push_back(d1);
    rx_stream.push_back(d2);
    rx_stream.push_back(ChEnd);
  endfunction

  // Mostly back-to-back, some short gaps, the odd long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Monitor: every accepted beat on either side goes through the ledger.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) ledger.take_byte(byte_ch.rx_byte);
      if (result_ch.valid && result_ch.ready)
        ledger.check_pair(result_ch.target_value, result_ch.real_value);
    end
  end

  // Result side: alternating ready/stall stretches, quiet spells with no stalls,
  // and one long hold-off so the result register stays full and input backs up.
  initial begin : result_sink
    int stretch;
    int stall;
    int round;
    bit held_long;
    result_ch.ready = 1'b0;
    round = 0;
    held_long = 1'b0;
    wait (rst_ni);
    forever begin
      stretch = $urandom_range(1, 12);
      @(negedge clk_i);
      result_ch.ready <= 1'b1;
      repeat (stretch - 1) @(negedge clk_i);
      if (!held_long && ledger.pairs_checked >= HoldAfter) begin
        held_long = 1'b1;
        @(negedge clk_i);
        result_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end
      stall = pick_gap();
      if ((round / 40) % 3 == 2) stall = 0;
      if (stall > 0) begin
        @(negedge clk_i);
        result_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      round++;
    end
  end

  // Watchdog: a long run of cycles with no beat on either side ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (rst_ni && ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat for %0d cycles, %0d pairs still owed", $time, quiet,
             ledger.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : byte_source
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] d1;
    logic [ByteW-1:0] d2;
    logic [ByteW-1:0] chk;
    int roll;
    int gap;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;

    // -- directed --
    // stray end letter while idle: drops to idle, nothing else
    rx_stream.push_back(ChEnd);
    // target frame at the data extremes, with ignored bytes in head and data-end phases
    rx_stream.push_back(ChHead1);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(ChHead2);
    rx_stream.push_back(ChTarget);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h80);
    rx_stream.push_back(ChEnd);
    rx_stream.push_back(frame_sum(ChTarget, 8'hFF, 8'hFF));
    // real frame of zeros; bad checksum, then a letter in the check phase, then the match
    chk = frame_sum(ChReal, 8'h00, 8'h00);
    push_frame(ChReal, 8'h00, 8'h00);
    rx_stream.push_back(chk + 8'd1);
    rx_stream.push_back(ChHead1);
    rx_stream.push_back(chk);
    // start letter as a data byte restarts mid-frame; the half-written target sticks
    rx_stream.push_back(ChHead1);
    rx_stream.push_back(ChHead2);
    rx_stream.push_back(ChTarget);
    rx_stream.push_back(8'h12);
    push_frame(ChReal, 8'h34, 8'h56);
    rx_stream.push_back(frame_sum(ChReal, 8'h34, 8'h56));

    // -- random --
    // Mostly whole frames with random payload, some with bad checksums first,
    // plus cut-off frames and noise weighted towards frame letters.
    while (rx_stream.size() < StreamLen) begin
      roll = $urandom_range(0, 99);
      cmd = $urandom_range(0, 1) ? ChReal : ChTarget;
      d1 = 8'($urandom_range(0, 255));
      d2 = 8'($urandom_range(0, 255));
      chk = frame_sum(cmd, d1, d2);
      if (roll < 78) begin
        push_frame(cmd, d1, d2);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) rx_stream.push_back(chk ^ 8'($urandom_range(1, 255)));
        end
        rx_stream.push_back(chk);
      end else if (roll < 90) begin
        // cut short before the end letter so the parser never sits in the check phase
        push_frame(cmd, d1, d2);
        repeat ($urandom_range(1, 5)) void'(rx_stream.pop_back());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
              0: rx_stream.push_back(ChHead1);
              1: rx_stream.push_back(ChHead2);
              2: rx_stream.push_back(ChTarget);
              3: rx_stream.push_back(ChReal);
              default: rx_stream.push_back(ChEnd);
            endcase
          end else begin
            rx_stream.push_back(8'($urandom_range(0, 255)));
          end
        end
      end
    end

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drive on falling edges; valid only drops when a gap is taken, so a held valid
    // never sees two assignments in one step.
    foreach (rx_stream[i]) begin
      gap = pick_gap();
      if ((i / 160) % 4 == 3) gap = 0;
      @(negedge clk_i);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      byte_ch.valid   <= 1'b1;
      byte_ch.rx_byte <= rx_stream[i];
      do @(posedge clk_i); while (!byte_ch.ready);
    end
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    // the monitor has seen the last byte by now; wait for every owed pair, then drain
    while (ledger.outstanding() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (ledger.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/csfp_pkg.sv
rtl/csfp_if.sv
rtl/csfp_in_stage.sv
rtl/csfp_core.sv
rtl/csfp_out_stage.sv
rtl/checksummed_setpoint_frame_parser.sv
verif/checksummed_setpoint_frame_parser_test.sv
